@@ src/slcd_pkg.sv @@
package slcd_pkg;

   // Framing constants
   localparam logic [7:0]  SYNC_BYTE = 8'hA5;
   localparam logic [15:0] CRC_POLY  = 16'h1021;

   // Default frame buffer size in bytes
   localparam int BUFFER_BYTES_DEFAULT = 512;

   // Receiver capacity after reset
   localparam logic [9:0] CAPACITY_RESET = 10'd512;

   // Depth of the small queues between the parts
   localparam int QUEUE_DEPTH = 2;

   // Frame header layout: two sync bytes, two free bytes, two length bytes
   localparam int HEADER_BYTES = 6;
   localparam int LEN_LOW_POS  = 4;
   localparam int LEN_HIGH_POS = 5;
   localparam int CRC_BYTES    = 2;

   // Width of the computed frame length (6 + 65535 + 2)
   localparam int EXP_W = 17;

   typedef enum logic [2:0] {
      STAT_NONE      = 3'd0,
      STAT_GOOD      = 3'd1,
      STAT_CRC_BAD   = 3'd2,
      STAT_OVER_CAP  = 3'd3,
      STAT_TOO_BIG   = 3'd4,
      STAT_SYNC_LOST = 3'd5
   } status_type;

   // Word passed from the front to the back
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       is_sync;
   } front_item_type;

   // Word passed out on the result side
   typedef struct packed {
      logic [7:0] out_byte;
      logic       in_frame;
      logic [8:0] position;
      status_type frame_status;
      logic [9:0] total_length;
   } result_type;

endpackage

@@ src/sync_length_crc_deframer.sv @@
// A pushed word is held in the input queue, then in the output queue, before it reaches rsp_.
// Throughput: one byte per cycle if unstalled, set by the back stage byte-wide CRC-16 update.
// Both sides stall independently through two-entry queues at the input and the output.
// Reset is synchronous and active high: queues empty, frame hunt restarts, CRC and
// length state clear, and receiver capacity returns to 512.
module sync_length_crc_deframer import slcd_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_in_frame,
   output logic [8:0] rsp_position,
   output logic [2:0] rsp_frame_status,
   output logic [9:0] rsp_total_length,
   input  logic       csr_wen,
   input  logic [9:0] csr_wdata
);

   front_item_type item;
   logic           item_valid;
   logic           item_pop;
   result_type     result;

   // Accept and classify raw bytes
   slcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .item_valid  (item_valid),
      .item_pop    (item_pop),
      .item        (item)
   );

   // Track the frame, run the CRC, report status
   slcd_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .result     (result)
   );

   assign rsp_out_byte     = result.out_byte;
   assign rsp_in_frame     = result.in_frame;
   assign rsp_position     = result.position;
   assign rsp_frame_status = result.frame_status;
   assign rsp_total_length = result.total_length;

endmodule

@@ src/slcd_fifo.sv @@
module slcd_fifo import slcd_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth, track the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff == CNT_W'(DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with fill count");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("queue reports full and empty together");

endmodule

@@ src/slcd_front.sv @@
module slcd_front import slcd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   output logic           req_full,
   input  logic [7:0]     req_rx_byte,
   output logic           item_valid,
   input  logic           item_pop,
   output front_item_type item
);

   front_item_type item_in;
   logic           item_empty;

   // Classify the byte as sync or not on the way in
   always_comb begin
      item_in.rx_byte = req_rx_byte;
      item_in.is_sync = (req_rx_byte == SYNC_BYTE);
   end

   // Hold accepted words until the back takes them
   slcd_fifo #(
      .WIDTH ($bits(front_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_in_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (item_in),
      .full      (req_full),
      .pop       (item_pop),
      .pop_data  (item),
      .empty     (item_empty)
   );

   assign item_valid = ~item_empty;

endmodule

@@ src/slcd_back.sv @@
module slcd_back import slcd_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   output logic           item_pop,
   input  front_item_type item,
   input  logic           csr_wen,
   input  logic [9:0]     csr_wdata,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output result_type     result
);

   localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

   logic [9:0]       capacity_ff;
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       len_low_ff, len_low_in;
   logic [EXP_W-1:0] exp_len_ff, exp_len_in;
   logic [7:0]       crc_low_ff, crc_low_in;

   logic             out_full;
   logic             go;
   logic [CNT_W-1:0] pos;
   logic [15:0]      crc_base;
   logic [15:0]      crc_next;
   logic [EXP_W-1:0] pos_plus;
   logic [EXP_W-1:0] len_new;
   logic [15:0]      rx_crc;
   result_type       res_in;

   // Byte-wide CRC-16 update, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   assign go       = item_valid & ~out_full;
   assign item_pop = go;

   // Position of this byte, restarting if the buffer would overflow
   assign pos      = (byte_count_ff >= CNT_W'(BUFFER_BYTES)) ? '0 : byte_count_ff;
   assign crc_base = (pos == '0) ? 16'h0000 : crc_ff;
   assign crc_next = crc_byte(crc_base, item.rx_byte);
   assign pos_plus = EXP_W'(pos) + EXP_W'(CRC_BYTES);
   assign len_new  = EXP_W'(HEADER_BYTES + CRC_BYTES) + EXP_W'(len_low_ff)
                   + EXP_W'({item.rx_byte, 8'h00});
   assign rx_crc   = {item.rx_byte, crc_low_ff};

   // Classify the byte against the frame state and build the result
   always_comb begin
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      len_low_in    = len_low_ff;
      exp_len_in    = exp_len_ff;
      crc_low_in    = crc_low_ff;

      res_in.out_byte     = item.rx_byte;
      res_in.in_frame     = 1'b0;
      res_in.position     = '0;
      res_in.frame_status = STAT_NONE;
      res_in.total_length = '0;

      if (byte_count_ff == '0 && !item.is_sync) begin
         // hunting: drop noise
      end else if (byte_count_ff == CNT_W'(1) && !item.is_sync) begin
         byte_count_in       = '0;
         crc_in              = '0;
         res_in.frame_status = STAT_SYNC_LOST;
      end else begin
         byte_count_in   = pos + 1'b1;
         res_in.in_frame = 1'b1;
         res_in.position = 9'(pos);
         if (pos < CNT_W'(HEADER_BYTES)) begin
            crc_in = crc_next;
            if (pos == CNT_W'(LEN_LOW_POS)) begin
               len_low_in = item.rx_byte;
            end
            if (pos == CNT_W'(LEN_HIGH_POS)) begin
               exp_len_in = len_new;
               if (len_new > EXP_W'(BUFFER_BYTES)) begin
                  res_in.frame_status = STAT_TOO_BIG;
                  byte_count_in       = '0;
                  crc_in              = '0;
               end
            end
         end else if (pos_plus < exp_len_ff) begin
            crc_in = crc_next;
         end else if (pos_plus == exp_len_ff) begin
            crc_low_in = item.rx_byte;
         end else begin
            priority if (rx_crc != crc_ff) begin
               res_in.frame_status = STAT_CRC_BAD;
            end else if (exp_len_ff > EXP_W'(capacity_ff)) begin
               res_in.frame_status = STAT_OVER_CAP;
            end else begin
               res_in.frame_status = STAT_GOOD;
            end
            res_in.total_length = exp_len_ff[9:0];
            byte_count_in       = '0;
            crc_in              = '0;
         end
      end
   end

   // Advance frame state on each processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         crc_ff        <= '0;
         len_low_ff    <= '0;
         exp_len_ff    <= '0;
         crc_low_ff    <= '0;
      end else if (go) begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         len_low_ff    <= len_low_in;
         exp_len_ff    <= exp_len_in;
         crc_low_ff    <= crc_low_in;
      end
   end

   // Hold the capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wen) begin
         capacity_ff <= csr_wdata;
      end
   end

   // Queue results so the result side can stall on its own
   slcd_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (go),
      .push_data (res_in),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (result),
      .empty     (rsp_empty)
   );

   a_count_below_buffer: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff < CNT_W'(BUFFER_BYTES))
      else $error("frame byte count reached buffer size");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      go && (res_in.frame_status == STAT_GOOD || res_in.frame_status == STAT_CRC_BAD
             || res_in.frame_status == STAT_OVER_CAP) |=> byte_count_ff == '0)
      else $error("hunt did not restart after frame end");

   a_body_in_frame: assert property (@(posedge clock) disable iff (reset)
      go && byte_count_ff > CNT_W'(1) |-> res_in.in_frame)
      else $error("byte inside a frame not marked in frame");

endmodule
